FILE: rtl/sbt_pkg.sv
// sbt_pkg: shared types and constants of the sorted bucket table
// no dependencies; used by sbt_cmp, sorted_bucket_table and the bench
package sbt_pkg;

  localparam int NumBucketsDef  = 8;
  localparam int BucketDepthDef = 8;
  localparam int ValueWidthDef  = 32;
  localparam int MaxResults     = 64;
  localparam int FillMax        = 127;

  localparam int OpW     = 2;
  localparam int BucketW = 3;
  localparam int EchoW   = 32;
  localparam int CapW    = 4;
  localparam int StatusW = 3;
  localparam int FillW   = 7;
  localparam int KW      = 7;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_LIST   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL        = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY       = 3'd3;
  localparam logic [StatusW-1:0] ST_TABLE_EMPTY = 3'd4;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_INS_CHK = 13'b0000000000010,
    S_INS_RD  = 13'b0000000000100,
    S_INS_CMP = 13'b0000000001000,
    S_DEL_CHK = 13'b0000000010000,
    S_DEL_RD  = 13'b0000000100000,
    S_DEL_CMP = 13'b0000001000000,
    S_DEL_SRD = 13'b0000010000000,
    S_DEL_SWR = 13'b0000100000000,
    S_SUM     = 13'b0001000000000,
    S_MRG_RD  = 13'b0010000000000,
    S_MRG_CMP = 13'b0100000000000,
    S_RESP    = 13'b1000000000000
  } state_t;

endpackage

FILE: rtl/sbt_mem.sv
// sbt_mem: single port value store with registered read
// depends on nothing beyond its parameters
module sbt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wr_data,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: rtl/sbt_cmp.sv
// sbt_cmp: shared signed compare unit
// depends on sbt_pkg for the result struct
module sbt_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output sbt_pkg::cmp_res_t res
);

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = (a == b);
  end

endmodule

FILE: rtl/sorted_bucket_table.sv
// sorted_bucket_table: top level, sequencer, bucket registers and output stage
// depends on sbt_pkg, sbt_mem and sbt_cmp
//
// usage
//   s_axis carries one command per transaction: insert, delete or list all
//   m_axis returns the results; insert and delete give one transaction each,
//   an unknown op gives none, a list all one per stored value in ascending
//   order (at most 64, tlast on the final one) or one if the table is empty
// sequencing
//   insert: compares the new value with the entries from the top down,
//   moving each larger one up; delete: scans from the bottom for a match,
//   then shifts the entries above it down; list all: totals the bucket
//   counts, then each merge round reads every bucket head and emits the
//   smallest, the lowest bucket on ties; all steps share the single value
//   store port and the one shared comparator; one command is worked on at
//   a time, s_axis_tready is high only while the sequencer is idle
// reset
//   rst clears bucket counts, capacities and created flags; the store
//   itself is not cleared, only entries below a count are ever read
// stalls
//   a result sits in the output register until taken; the sequencer waits
//   on it before loading the next result, no transaction is dropped
module sorted_bucket_table #(
  parameter int NUM_BUCKETS  = sbt_pkg::NumBucketsDef,
  parameter int BUCKET_DEPTH = sbt_pkg::BucketDepthDef,
  parameter int VALUE_WIDTH  = sbt_pkg::ValueWidthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // bucket [2:0], value [34:3], capacity [38:35], zero pad
  input  logic [sbt_pkg::InDataW-1:0]   s_axis_tdata,
  // op [1:0]
  input  logic [sbt_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // value_res [31:0], fill [38:32], zero pad
  output logic [sbt_pkg::OutDataW-1:0]  m_axis_tdata,
  // status [2:0]
  output logic [sbt_pkg::StatusW-1:0]   m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CW    = $clog2(BUCKET_DEPTH + 1);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int VW    = VALUE_WIDTH;

  // input fields
  logic [sbt_pkg::BucketW-1:0] in_bucket;
  logic [sbt_pkg::EchoW-1:0]   in_value;
  logic [sbt_pkg::CapW-1:0]    in_cap;
  logic                        in_acc;

  assign in_bucket = s_axis_tdata[2:0];
  assign in_value  = s_axis_tdata[34:3];
  assign in_cap    = s_axis_tdata[38:35];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // sequencer state
  sbt_pkg::state_t state;
  logic [sbt_pkg::OpW-1:0]   op_r;
  logic                      oor;
  logic [BIW-1:0]            bi;
  logic [sbt_pkg::CapW-1:0]  cap_r;
  logic signed [VW-1:0]      val_r;
  logic [sbt_pkg::EchoW-1:0] echo_r;
  logic [CW-1:0]             p;
  logic [CW-1:0]             n_r;
  logic signed [VW-1:0]      best_val;
  logic [BIW-1:0]            best_b;
  logic                      have_best;
  logic [TW-1:0]             total;
  logic [sbt_pkg::KW-1:0]    k;
  logic                      more;

  // pending result
  logic [sbt_pkg::StatusW-1:0] res_status;
  logic [sbt_pkg::EchoW-1:0]   res_val;
  logic [sbt_pkg::FillW-1:0]   res_fill;
  logic                        res_last;

  // per-bucket registers
  logic [CW-1:0] count   [NUM_BUCKETS];
  logic [CW-1:0] limit   [NUM_BUCKETS];
  logic          created [NUM_BUCKETS];
  logic [CW-1:0] cur     [NUM_BUCKETS];

  // store and compare unit
  logic          mem_wr;
  logic          mem_rd;
  logic [AW-1:0] mem_addr;
  logic [VW-1:0] mem_wdata;
  logic [VW-1:0] mem_rdata;
  logic [CW-1:0] idx;
  logic [VW-1:0] cmp_a;
  logic [VW-1:0] cmp_b;
  sbt_pkg::cmp_res_t cmp;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // derived values
  logic [TW-1:0]          total_next;
  logic [sbt_pkg::KW-1:0] emit;
  logic [sbt_pkg::FillW-1:0] fill_sat;
  logic [CW-1:0]          new_lim;
  logic                   bi_last;

  assign total_next = total + TW'(count[bi]);
  assign emit       = (32'(total) > sbt_pkg::MaxResults) ?
                      sbt_pkg::KW'(sbt_pkg::MaxResults) : sbt_pkg::KW'(total);
  assign fill_sat   = (32'(total) > sbt_pkg::FillMax) ?
                      sbt_pkg::FillW'(sbt_pkg::FillMax) : sbt_pkg::FillW'(total);
  assign new_lim    = (32'(cap_r) > BUCKET_DEPTH) ? CW'(BUCKET_DEPTH) : CW'(cap_r);
  assign bi_last    = (bi == BIW'(NUM_BUCKETS - 1));

  // address and write data of the store, one access per cycle
  always_comb begin
    idx       = p;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    mem_wdata = val_r;
    unique case (state)
      sbt_pkg::S_INS_RD: begin
        if (p == '0) begin
          idx    = '0;
          mem_wr = 1'b1;
        end else begin
          idx    = p - CW'(1);
          mem_rd = 1'b1;
        end
      end
      sbt_pkg::S_INS_CMP: begin
        mem_wr    = 1'b1;
        mem_wdata = cmp.lt ? mem_rdata : val_r;
      end
      sbt_pkg::S_DEL_RD: begin
        mem_rd = (p != n_r);
      end
      sbt_pkg::S_DEL_SRD: begin
        idx    = p + CW'(1);
        mem_rd = ((p + CW'(1)) < n_r);
      end
      sbt_pkg::S_DEL_SWR: begin
        mem_wr    = 1'b1;
        mem_wdata = mem_rdata;
      end
      sbt_pkg::S_MRG_RD: begin
        idx    = cur[bi];
        mem_rd = (cur[bi] < count[bi]);
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = AW'(bi) * AW'(BUCKET_DEPTH) + AW'(idx[IW-1:0]);

  // merge compares the fetched head against the best so far
  assign cmp_a = (state == sbt_pkg::S_MRG_CMP) ? mem_rdata : val_r;
  assign cmp_b = (state == sbt_pkg::S_MRG_CMP) ? best_val : mem_rdata;

  sbt_mem #(.DEPTH(DEPTH), .AW(AW), .W(VW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .rd_en   (mem_rd),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  sbt_cmp #(.W(VW)) u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign s_axis_tready = (state == sbt_pkg::S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbt_pkg::S_IDLE;
      k     <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        count[i]   <= '0;
        limit[i]   <= '0;
        created[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        sbt_pkg::S_IDLE: begin
          if (in_acc) begin
            op_r   <= s_axis_tuser;
            oor    <= (32'(in_bucket) >= NUM_BUCKETS);
            bi     <= BIW'(in_bucket);
            cap_r  <= in_cap;
            val_r  <= VW'($signed(in_value));
            echo_r <= in_value;
            more   <= 1'b0;
            unique case (s_axis_tuser)
              sbt_pkg::OP_INSERT: state <= sbt_pkg::S_INS_CHK;
              sbt_pkg::OP_DELETE: state <= sbt_pkg::S_DEL_CHK;
              sbt_pkg::OP_LIST: begin
                bi    <= '0;
                total <= '0;
                state <= sbt_pkg::S_SUM;
              end
              default: state <= sbt_pkg::S_IDLE;
            endcase
          end
        end
        sbt_pkg::S_INS_CHK: begin
          res_val  <= echo_r;
          res_last <= 1'b1;
          if (oor) begin
            res_status <= sbt_pkg::ST_FULL;
            res_fill   <= '0;
            state      <= sbt_pkg::S_RESP;
          end else if (!created[bi]) begin
            // first use creates the bucket with a saturated capacity
            created[bi] <= 1'b1;
            limit[bi]   <= new_lim;
            count[bi]   <= '0;
            p           <= '0;
            n_r         <= '0;
            if (new_lim == '0) begin
              res_status <= sbt_pkg::ST_FULL;
              res_fill   <= '0;
              state      <= sbt_pkg::S_RESP;
            end else begin
              state <= sbt_pkg::S_INS_RD;
            end
          end else if (count[bi] >= limit[bi]) begin
            res_status <= sbt_pkg::ST_FULL;
            res_fill   <= sbt_pkg::FillW'(count[bi]);
            state      <= sbt_pkg::S_RESP;
          end else begin
            p     <= count[bi];
            n_r   <= count[bi];
            state <= sbt_pkg::S_INS_RD;
          end
        end
        sbt_pkg::S_INS_RD: begin
          if (p == '0) begin
            count[bi]  <= n_r + CW'(1);
            res_status <= sbt_pkg::ST_OK;
            res_fill   <= sbt_pkg::FillW'(n_r + CW'(1));
            state      <= sbt_pkg::S_RESP;
          end else begin
            state <= sbt_pkg::S_INS_CMP;
          end
        end
        sbt_pkg::S_INS_CMP: begin
          if (cmp.lt) begin
            p     <= p - CW'(1);
            state <= sbt_pkg::S_INS_RD;
          end else begin
            count[bi]  <= n_r + CW'(1);
            res_status <= sbt_pkg::ST_OK;
            res_fill   <= sbt_pkg::FillW'(n_r + CW'(1));
            state      <= sbt_pkg::S_RESP;
          end
        end
        sbt_pkg::S_DEL_CHK: begin
          res_val  <= echo_r;
          res_last <= 1'b1;
          if (oor || count[bi] == '0) begin
            res_status <= sbt_pkg::ST_EMPTY;
            res_fill   <= '0;
            state      <= sbt_pkg::S_RESP;
          end else begin
            n_r   <= count[bi];
            p     <= '0;
            state <= sbt_pkg::S_DEL_RD;
          end
        end
        sbt_pkg::S_DEL_RD: begin
          if (p == n_r) begin
            res_status <= sbt_pkg::ST_NOT_FOUND;
            res_fill   <= sbt_pkg::FillW'(n_r);
            state      <= sbt_pkg::S_RESP;
          end else begin
            state <= sbt_pkg::S_DEL_CMP;
          end
        end
        sbt_pkg::S_DEL_CMP: begin
          if (cmp.eq) begin
            state <= sbt_pkg::S_DEL_SRD;
          end else begin
            p     <= p + CW'(1);
            state <= sbt_pkg::S_DEL_RD;
          end
        end
        sbt_pkg::S_DEL_SRD: begin
          if ((p + CW'(1)) >= n_r) begin
            count[bi]  <= n_r - CW'(1);
            res_status <= sbt_pkg::ST_OK;
            res_fill   <= sbt_pkg::FillW'(n_r - CW'(1));
            state      <= sbt_pkg::S_RESP;
          end else begin
            state <= sbt_pkg::S_DEL_SWR;
          end
        end
        sbt_pkg::S_DEL_SWR: begin
          p     <= p + CW'(1);
          state <= sbt_pkg::S_DEL_SRD;
        end
        sbt_pkg::S_SUM: begin
          total   <= total_next;
          cur[bi] <= '0;
          if (bi_last) begin
            bi        <= '0;
            k         <= '0;
            have_best <= 1'b0;
            if (total_next == '0) begin
              res_status <= sbt_pkg::ST_TABLE_EMPTY;
              res_val    <= '0;
              res_fill   <= '0;
              res_last   <= 1'b1;
              state      <= sbt_pkg::S_RESP;
            end else begin
              state <= sbt_pkg::S_MRG_RD;
            end
          end else begin
            bi <= bi + BIW'(1);
          end
        end
        sbt_pkg::S_MRG_RD, sbt_pkg::S_MRG_CMP: begin
          if (state == sbt_pkg::S_MRG_RD && cur[bi] < count[bi]) begin
            state <= sbt_pkg::S_MRG_CMP;
          end else begin
            // bucket done for this round: fold in the fetched head, if one was read
            logic take;
            logic signed [VW-1:0] bv;
            logic [BIW-1:0] bb;
            take = (state == sbt_pkg::S_MRG_CMP) && (!have_best || cmp.lt);
            bv   = take ? mem_rdata : best_val;
            bb   = take ? bi : best_b;
            if (take) begin
              best_val  <= mem_rdata;
              best_b    <= bi;
              have_best <= 1'b1;
            end
            if (bi_last) begin
              cur[bb]    <= cur[bb] + CW'(1);
              res_status <= sbt_pkg::ST_OK;
              res_val    <= sbt_pkg::EchoW'(bv);
              res_fill   <= fill_sat;
              res_last   <= (k + sbt_pkg::KW'(1) == emit);
              more       <= (k + sbt_pkg::KW'(1) != emit);
              k          <= k + sbt_pkg::KW'(1);
              state      <= sbt_pkg::S_RESP;
            end else begin
              bi    <= bi + BIW'(1);
              state <= sbt_pkg::S_MRG_RD;
            end
          end
        end
        sbt_pkg::S_RESP: begin
          if (out_free) begin
            if (more) begin
              bi        <= '0;
              have_best <= 1'b0;
              state     <= sbt_pkg::S_MRG_RD;
            end else begin
              state <= sbt_pkg::S_IDLE;
            end
          end
        end
        default: state <= sbt_pkg::S_IDLE;
      endcase
    end
  end

  // output register, holds its transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == sbt_pkg::S_RESP && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {1'b0, res_fill, res_val};
      m_axis_tuser  <= res_status;
      m_axis_tlast  <= res_last;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // checks
  a_ins_cmp_has_slot: assert property (@(posedge clk) disable iff (rst)
    state == sbt_pkg::S_INS_CMP |-> p != '0)
    else $error("insert compare with no entry below");

  a_merge_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == sbt_pkg::S_MRG_RD && bi_last && cur[bi] >= count[bi]) |-> have_best)
    else $error("merge round ended with no candidate");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    32'(k) <= sbt_pkg::MaxResults)
    else $error("list emitted too many values");

  a_resp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == sbt_pkg::S_RESP && !out_free) |=> state == sbt_pkg::S_RESP)
    else $error("result left while output stalled");

endmodule

FILE: tb/sv/sorted_bucket_table_tb.sv
// sorted_bucket_table_tb: self-checking bench for the sorted bucket table
// drives commands on s_axis, predicts results with its own table model, checks m_axis
// depends on sbt_pkg and sorted_bucket_table
`timescale 1ns / 1ps

module sorted_bucket_table_tb;

  localparam int NB = 8;
  localparam int DEPTH = 8;
  localparam int N_RANDOM = 400;
  localparam int WATCHDOG = 20000;
  localparam logic [sbt_pkg::OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [sbt_pkg::StatusW-1:0] status;
    logic [31:0]                 value;
    logic [sbt_pkg::FillW-1:0]   fill;
    logic                        last;
  } result_t;

  typedef struct {
    logic [sbt_pkg::OpW-1:0] op;
    logic [2:0]     bucket;
    logic [31:0]    value;
    logic [3:0]     capacity;
    bit             has_exp;  // typed-in expectation for the first result
    result_t        exp;
  } cmd_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [sbt_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic [sbt_pkg::OpW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [sbt_pkg::OutDataW-1:0] m_axis_tdata;
  logic [sbt_pkg::StatusW-1:0] m_axis_tuser;
  logic m_axis_tlast;

  sorted_bucket_table DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // table model state
  logic signed [31:0] tbl_vals [NB][DEPTH];
  int unsigned tbl_count [NB];
  int unsigned tbl_cap [NB];
  bit tbl_made [NB];

  result_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_lists = 0;
  bit calm = 0;        // no idling near the end
  bit hold_off = 0;    // long receiver stall
  bit stim_done = 0;
  int stall_left = 0;

  function automatic result_t mk(logic [sbt_pkg::StatusW-1:0] st, logic [31:0] v, int f,
                                 bit l);
    result_t r;
    r.status = st;
    r.value = v;
    r.fill = (f > sbt_pkg::FillMax) ? sbt_pkg::FillW'(sbt_pkg::FillMax) : sbt_pkg::FillW'(f);
    r.last = l;
    return r;
  endfunction

  // work out results of one command and update the table model
  task automatic table_apply(input cmd_t c, output int n_res);
    int b, n, p, i, total, k, best;
    int cur [NB];
    logic signed [31:0] v;
    bit found;
    b = c.bucket;
    v = c.value;
    n_res = 1;
    case (c.op)
      sbt_pkg::OP_INSERT: begin
        if (!tbl_made[b]) begin
          tbl_made[b] = 1;
          tbl_cap[b] = (c.capacity > DEPTH) ? DEPTH : c.capacity;
          tbl_count[b] = 0;
        end
        n = tbl_count[b];
        if (n >= tbl_cap[b]) begin
          pending_results.push_back(mk(sbt_pkg::ST_FULL, c.value, n, 1));
        end else begin
          p = n;
          while (p > 0 && v < tbl_vals[b][p-1]) begin
            tbl_vals[b][p] = tbl_vals[b][p-1];
            p--;
          end
          tbl_vals[b][p] = v;
          tbl_count[b] = n + 1;
          pending_results.push_back(mk(sbt_pkg::ST_OK, c.value, n + 1, 1));
        end
      end
      sbt_pkg::OP_DELETE: begin
        n = tbl_count[b];
        found = 0;
        if (n == 0) begin
          pending_results.push_back(mk(sbt_pkg::ST_EMPTY, c.value, 0, 1));
        end else begin
          for (i = 0; i < n && !found; i++)
            if (tbl_vals[b][i] == v) begin
              found = 1;
              for (p = i; p + 1 < n; p++) tbl_vals[b][p] = tbl_vals[b][p+1];
            end
          if (found) begin
            tbl_count[b] = n - 1;
            pending_results.push_back(mk(sbt_pkg::ST_OK, c.value, n - 1, 1));
          end else begin
            pending_results.push_back(mk(sbt_pkg::ST_NOT_FOUND, c.value, n, 1));
          end
        end
      end
      sbt_pkg::OP_LIST: begin
        total = 0;
        foreach (cur[j]) begin
          cur[j] = 0;
          total += tbl_count[j];
        end
        if (total == 0) begin
          pending_results.push_back(mk(sbt_pkg::ST_TABLE_EMPTY, '0, 0, 1));
        end else begin
          n_res = (total > sbt_pkg::MaxResults) ? sbt_pkg::MaxResults : total;
          // merge: smallest head, lowest bucket wins ties
          for (k = 0; k < n_res; k++) begin
            best = -1;
            for (i = 0; i < NB; i++)
              if (cur[i] < tbl_count[i] &&
                  (best < 0 || tbl_vals[i][cur[i]] < tbl_vals[best][cur[best]]))
                best = i;
            pending_results.push_back(mk(sbt_pkg::ST_OK, tbl_vals[best][cur[best]], total,
                                         k + 1 == n_res));
            cur[best]++;
          end
        end
      end
      default: n_res = 0;  // unknown op gives nothing
    endcase
  endtask

  // hand one command to the block, with random gaps first
  task automatic send_cmd(input cmd_t c);
    int gap, n_res, first;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {1'b0, c.capacity, c.value, c.bucket};
    s_axis_tuser <= c.op;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    first = pending_results.size();
    table_apply(c, n_res);
    // typed expectation must agree with the table model
    if (c.has_exp && n_res > 0 && pending_results[first] != c.exp) begin
      $error("directed row %0d: model gives %p, table row says %p",
             n_sent, pending_results[first], c.exp);
      errors++;
    end
    n_sent++;
    if (c.op == sbt_pkg::OP_LIST) n_lists++;
  endtask

  function automatic cmd_t row(logic [sbt_pkg::OpW-1:0] op, int b, logic [31:0] v, int cap);
    cmd_t c;
    c.op = op;
    c.bucket = 3'(b);
    c.value = v;
    c.capacity = 4'(cap);
    c.has_exp = 0;
    c.exp = '0;
    return c;
  endfunction

  function automatic cmd_t row_x(logic [sbt_pkg::OpW-1:0] op, int b, logic [31:0] v, int cap,
                                 logic [sbt_pkg::StatusW-1:0] st, logic [31:0] ev, int f);
    cmd_t c;
    c = row(op, b, v, cap);
    c.has_exp = 1;
    c.exp = mk(st, ev, f, 1);
    return c;
  endfunction

  // receiver: random stall bursts, one long hold-off, always ready when calm
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      stall_left <= 0;
    end else if (hold_off) begin
      m_axis_tready <= 0;
    end else if (calm) begin
      m_axis_tready <= 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 0;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32], m_axis_tlast);
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.value !== want.value) begin
          $error("value_res: expected %0d, got %0d", $signed(want.value),
                 $signed(got.value)); errors++;
        end
        if (got.fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, got.fill); errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", WATCHDOG);
      $display("sorted_bucket_table_tb NOT OK");
      $finish;
    end
  end

  // one long receiver hold-off while commands keep coming
  initial begin
    wait (n_sent == 60);
    @(posedge clk);
    hold_off <= 1;
    repeat (300) @(posedge clk);
    hold_off <= 0;
  end

  cmd_t directed[$];
  initial begin
    cmd_t c;
    int b, kind;
    foreach (tbl_count[i]) begin
      tbl_count[i] = 0; tbl_cap[i] = 0; tbl_made[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;

    // after reset, extremes and error codes
    directed.push_back(row_x(sbt_pkg::OP_LIST, 0, 32'h0, 0, sbt_pkg::ST_TABLE_EMPTY, 32'h0, 0));
    directed.push_back(row_x(sbt_pkg::OP_DELETE, 2, 32'd5, 0, sbt_pkg::ST_EMPTY, 32'd5, 0));
    directed.push_back(row_x(sbt_pkg::OP_INSERT, 0, 32'h7fffffff, 15, sbt_pkg::ST_OK,
                             32'h7fffffff, 1));
    directed.push_back(row_x(sbt_pkg::OP_INSERT, 0, 32'h80000000, 0, sbt_pkg::ST_OK,
                             32'h80000000, 2));
    directed.push_back(row(sbt_pkg::OP_INSERT, 0, 32'h0, 0));
    directed.push_back(row(sbt_pkg::OP_INSERT, 0, 32'hffffffff, 0));
    directed.push_back(row(sbt_pkg::OP_INSERT, 0, 32'h0, 0));
    directed.push_back(row_x(sbt_pkg::OP_INSERT, 1, 32'd9, 0, sbt_pkg::ST_FULL, 32'd9, 0));
    directed.push_back(row_x(sbt_pkg::OP_INSERT, 1, 32'd9, 8, sbt_pkg::ST_FULL, 32'd9, 0));
    directed.push_back(row(sbt_pkg::OP_INSERT, 7, 32'h55555555, 2));
    directed.push_back(row(sbt_pkg::OP_INSERT, 7, 32'haaaaaaaa, 2));
    directed.push_back(row_x(sbt_pkg::OP_INSERT, 7, 32'd1, 2, sbt_pkg::ST_FULL, 32'd1, 2));
    directed.push_back(row(sbt_pkg::OP_LIST, 5, 32'hdeadbeef, 3));
    directed.push_back(row_x(sbt_pkg::OP_DELETE, 0, 32'd42, 0, sbt_pkg::ST_NOT_FOUND,
                             32'd42, 5));
    directed.push_back(row(sbt_pkg::OP_DELETE, 0, 32'h0, 0));
    directed.push_back(row(sbt_pkg::OP_DELETE, 0, 32'h7fffffff, 0));
    directed.push_back(row(sbt_pkg::OP_INSERT, 3, 32'd4, 15));
    directed.push_back(row(OP_UNUSED, 4, 32'hffffffff, 15));
    directed.push_back(row(sbt_pkg::OP_LIST, 0, 32'h0, 0));
    foreach (directed[i]) send_cmd(directed[i]);

    // random: mostly inserts to fill the table, deletes of stored values, lists
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 40) calm = 1;
      b = $urandom_range(0, 7);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        c = row(sbt_pkg::OP_INSERT, b,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) - 10,
                $urandom_range(0, 15));
      end else if (kind < 85) begin
        if (tbl_count[b] > 0 && $urandom_range(0, 3) != 0)
          c = row(sbt_pkg::OP_DELETE, b, tbl_vals[b][$urandom_range(0, tbl_count[b] - 1)],
                  $urandom_range(0, 15));
        else
          c = row(sbt_pkg::OP_DELETE, b, $urandom, $urandom_range(0, 15));
      end else if (kind < 97) begin
        c = row(sbt_pkg::OP_LIST, b, $urandom, $urandom_range(0, 15));
      end else begin
        c = row(OP_UNUSED, b, $urandom, $urandom_range(0, 15));
      end
      send_cmd(c);
    end
    s_axis_tvalid <= 0;
    stim_done = 1;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d commands sent (%0d list-all), %0d result transactions checked",
             n_sent, n_lists, n_checked);
    if (errors == 0) $display("sorted_bucket_table_tb OK");
    else $display("sorted_bucket_table_tb NOT OK");
    $finish;
  end

endmodule
